// ===== rtl/kmis_pkg.sv =====
// Package for the k-machine interval scheduler.
// Sizes, key layout and sequencer states; no dependencies.
package kmis_pkg;
  localparam int MAX_SHOWS     = 1024;
  localparam int MAX_RECORDERS = 64;
  localparam int TIME_W        = 31;
  localparam int IDX_W         = $clog2(MAX_SHOWS);
  localparam int CNT_W         = IDX_W + 1;
  localparam int REC_W         = (MAX_RECORDERS > 1) ? $clog2(MAX_RECORDERS) : 1;
  localparam int REG_W         = 7;
  localparam int KEY_W         = TIME_W + IDX_W;
  localparam int PADDR_W       = 3;
  localparam logic [PADDR_W-1:0] ADDR_RECORDER_COUNT = '0;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_INIT,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_FETCH,
    ST_FETCH_WAIT,
    ST_REC_RD,
    ST_REC_CMP,
    ST_ASSIGN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  rd_addr;
  } store_ctrl_t;
endpackage

// ===== rtl/kmis_store.sv =====
// Interval store: start and end times, one write and one registered read port.
// Depends on kmis_pkg.
module kmis_store (
  input  logic                       clk,
  input  kmis_pkg::store_ctrl_t      ctrl,
  input  logic [kmis_pkg::TIME_W-1:0] wr_start,
  input  logic [kmis_pkg::TIME_W-1:0] wr_end,
  output logic [kmis_pkg::TIME_W-1:0] rd_start,
  output logic [kmis_pkg::TIME_W-1:0] rd_end
);
  import kmis_pkg::*;

  logic [TIME_W-1:0] start_mem [MAX_SHOWS];
  logic [TIME_W-1:0] end_mem   [MAX_SHOWS];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      start_mem[ctrl.wr_addr] <= wr_start;
      end_mem[ctrl.wr_addr]   <= wr_end;
    end
    rd_start <= start_mem[ctrl.rd_addr];
    rd_end   <= end_mem[ctrl.rd_addr];
  end
endmodule

// ===== rtl/k_machine_interval_scheduler.sv =====
// Top level of the k-machine greedy interval scheduler.
// Depends on kmis_pkg and kmis_store.
//
// Use: intervals come in as beats on start/show_start/show_end/last_show,
// taken at an edge where start is high and busy is low. While loading,
// busy stays low and one beat is taken every cycle. Beats past MAX_SHOWS
// are dropped and remembered as overflow.
// A beat with last_show set closes the set; busy then rises and the
// sequencer works through the stored intervals in end-time order (ties in
// arrival order). Each pick is a full scan of the store through the
// single compare path, followed by a scan of the recorders.
// The result (scheduled_count, overflow) is shown for one cycle with
// result_valid; the receiver cannot stall it. busy falls at the same edge
// that raises result_valid, so the next set can load during that cycle.
// recorder_count is written over the APB port at byte address 0 and is
// sampled when the set closes. The user must write it only while idle;
// the block itself does not enforce this. Reset (rst, synchronous)
// empties the set, frees every recorder and sets recorder_count to 1.
module k_machine_interval_scheduler (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kmis_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic [kmis_pkg::TIME_W-1:0]  show_start,
  input  logic [kmis_pkg::TIME_W-1:0]  show_end,
  input  logic                         last_show,
  output logic                         result_valid,
  output logic [kmis_pkg::CNT_W-1:0]   scheduled_count,
  output logic                         overflow
);
  import kmis_pkg::*;

  localparam logic [REG_W-1:0] K_MAX = REG_W'(MAX_RECORDERS);

  state_t state, state_next;

  logic [REG_W-1:0]  recorder_count;
  logic [REG_W-1:0]  k_q;
  logic [CNT_W-1:0]  loaded_count;
  logic              overflow_seen;
  logic [CNT_W-1:0]  pick_cnt;     // intervals handled so far
  logic [CNT_W-1:0]  scan_j;       // store scan position
  logic [KEY_W-1:0]  prev_key;     // last handled {end, index}
  logic              has_prev;
  logic [KEY_W-1:0]  best_key;
  logic              found_key;
  logic [TIME_W-1:0] cur_start;
  logic [REG_W-1:0]  rec_r;
  logic              found_busy, found_free;
  logic [REC_W-1:0]  best_rec, free_rec;
  logic [TIME_W-1:0] best_end;
  logic [CNT_W-1:0]  done_cnt;
  logic [MAX_RECORDERS-1:0] rec_busy;
  logic [TIME_W-1:0] rec_end_mem [MAX_RECORDERS];
  logic [TIME_W-1:0] rec_rd;

  store_ctrl_t       sctl;
  logic [TIME_W-1:0] rd_start, rd_end;
  logic              accept, cfg_wr, cfg_hit;
  logic [KEY_W-1:0]  cand_key;
  logic [REC_W-1:0]  r_idx;
  logic              rec_ok;

  function automatic logic rec_end_mem_ok();
    return (rec_rd <= cur_start) && (!found_busy || rec_rd > best_end);
  endfunction

  // register index is paddr[2]; the low byte-lane bits are ignored
  assign cfg_hit = (paddr[PADDR_W-1:2] == ADDR_RECORDER_COUNT[PADDR_W-1:2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;
  assign prdata  = cfg_hit ? {{(32-REG_W){1'b0}}, recorder_count} : '0;
  assign busy    = (state != ST_LOAD);
  assign accept  = start && !busy;
  assign cand_key = {rd_end, scan_j[IDX_W-1:0]};
  assign r_idx   = rec_r[REC_W-1:0];
  assign rec_ok  = rec_end_mem_ok();

  always_comb begin
    sctl.wr_en   = accept && (loaded_count < CNT_W'(MAX_SHOWS));
    sctl.wr_addr = loaded_count[IDX_W-1:0];
    sctl.rd_addr = (state == ST_FETCH) ? best_key[IDX_W-1:0] : scan_j[IDX_W-1:0];
  end

  kmis_store u_store (
    .clk      (clk),
    .ctrl     (sctl),
    .wr_start (show_start),
    .wr_end   (show_end),
    .rd_start (rd_start),
    .rd_end   (rd_end)
  );

  // recorder busy-end memory, registered read
  always_ff @(posedge clk) begin
    if (state == ST_ASSIGN && (found_busy || found_free)) begin
      rec_end_mem[found_busy ? best_rec : free_rec] <= best_key[KEY_W-1:IDX_W];
    end
    rec_rd <= rec_end_mem[r_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:       if (accept && last_show) state_next = ST_SORT_INIT;
      ST_SORT_INIT:  state_next = (loaded_count == '0) ? ST_DONE : ST_SORT_RD;
      ST_SORT_RD:    state_next = ST_SORT_CMP;
      ST_SORT_CMP:   state_next = (scan_j + 1'b1 == loaded_count) ? ST_FETCH : ST_SORT_RD;
      ST_FETCH:      state_next = ST_FETCH_WAIT;
      ST_FETCH_WAIT: state_next = (k_q == '0) ? ST_ASSIGN : ST_REC_RD;
      ST_REC_RD:     state_next = ST_REC_CMP;
      ST_REC_CMP:    state_next = (rec_r + 1'b1 == k_q) ? ST_ASSIGN : ST_REC_RD;
      ST_ASSIGN:     state_next = (pick_cnt + 1'b1 == loaded_count) ? ST_DONE : ST_SORT_INIT;
      ST_DONE:       state_next = ST_LOAD;
      default:       state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recorder_count <= REG_W'(1);
      loaded_count   <= '0;
      overflow_seen  <= 1'b0;
      rec_busy       <= '0;
      result_valid   <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_wr) recorder_count <= pwdata[REG_W-1:0];
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (loaded_count < CNT_W'(MAX_SHOWS)) loaded_count <= loaded_count + 1'b1;
            else overflow_seen <= 1'b1;
            if (last_show) begin
              k_q      <= (recorder_count > K_MAX) ? K_MAX : recorder_count;
              pick_cnt <= '0;
              has_prev <= 1'b0;
              done_cnt <= '0;
              rec_busy <= '0;
            end
          end
        end
        ST_SORT_INIT: begin
          scan_j    <= '0;
          found_key <= 1'b0;
        end
        ST_SORT_CMP: begin
          // next interval in {end, index} order after the previous pick
          if ((!has_prev || cand_key > prev_key) && (!found_key || cand_key < best_key)) begin
            best_key  <= cand_key;
            found_key <= 1'b1;
          end
          scan_j <= scan_j + 1'b1;
        end
        ST_FETCH_WAIT: begin
          cur_start  <= rd_start;
          prev_key   <= best_key;
          has_prev   <= 1'b1;
          rec_r      <= '0;
          found_busy <= 1'b0;
          found_free <= 1'b0;
        end
        ST_REC_CMP: begin
          if (rec_busy[r_idx]) begin
            if (rec_ok) begin
              best_rec   <= r_idx;
              best_end   <= rec_rd;
              found_busy <= 1'b1;
            end
          end else if (!found_free) begin
            free_rec   <= r_idx;
            found_free <= 1'b1;
          end
          rec_r <= rec_r + 1'b1;
        end
        ST_ASSIGN: begin
          if (found_busy || found_free) begin
            rec_busy[found_busy ? best_rec : free_rec] <= 1'b1;
            done_cnt <= done_cnt + 1'b1;
          end
          pick_cnt <= pick_cnt + 1'b1;
        end
        ST_DONE: begin
          result_valid    <= 1'b1;
          scheduled_count <= done_cnt;
          overflow        <= overflow_seen;
          loaded_count    <= '0;
          overflow_seen   <= 1'b0;
          rec_busy        <= '0;
        end
        default: begin
        end
      endcase
    end
  end
endmodule

// ===== test/kmis_checker.sv =====
// Checker for the k-machine interval scheduler: watches the APB port and both beat channels,
// predicts each set's result and compares it. Depends on kmis_pkg.
module kmis_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [kmis_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  input  logic                         start,
  input  logic                         busy,
  input  logic [kmis_pkg::TIME_W-1:0]  show_start,
  input  logic [kmis_pkg::TIME_W-1:0]  show_end,
  input  logic                         last_show,
  input  logic                         result_valid,
  input  logic [kmis_pkg::CNT_W-1:0]   scheduled_count,
  input  logic                         overflow,
  output int                           fail_count,
  output int                           pending
);
  import kmis_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             ovf;
  } set_result_t;

  logic [TIME_W-1:0] set_start [MAX_SHOWS];
  logic [TIME_W-1:0] set_end   [MAX_SHOWS];
  logic [REG_W-1:0]  machines;
  int                set_len;
  logic              set_ovf;
  set_result_t       result_q [$];

  // Stable order by end, then greedy best-fit over busy machines, first free otherwise.
  function automatic logic [CNT_W-1:0] greedy_count(int n, int k);
    int                order [MAX_SHOWS];
    logic [TIME_W-1:0] mach_end [MAX_RECORDERS];
    logic              mach_busy [MAX_RECORDERS];
    int j, v, best, free_idx, done;
    logic found_busy, found_free;
    if (k > MAX_RECORDERS) k = MAX_RECORDERS;
    for (int r = 0; r < MAX_RECORDERS; r++) mach_busy[r] = 1'b0;
    for (int i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && set_end[order[j-1]] > set_end[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    done = 0;
    for (int i = 0; i < n; i++) begin
      v = order[i];
      found_busy = 1'b0;
      found_free = 1'b0;
      best = 0;
      free_idx = 0;
      for (int r = 0; r < k; r++) begin
        if (mach_busy[r]) begin
          if (mach_end[r] <= set_start[v] && (!found_busy || mach_end[r] > mach_end[best])) begin
            best = r;
            found_busy = 1'b1;
          end
        end else if (!found_free) begin
          free_idx = r;
          found_free = 1'b1;
        end
      end
      if (found_busy || found_free) begin
        if (!found_busy) best = free_idx;
        mach_busy[best] = 1'b1;
        mach_end[best] = set_end[v];
        done++;
      end
    end
    return done[CNT_W-1:0];
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    set_result_t exp_r;
    if (rst) begin
      machines   <= 7'd1;
      set_len    = 0;
      set_ovf    = 1'b0;
      fail_count = 0;
      result_q.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[PADDR_W-1:2] == ADDR_RECORDER_COUNT[PADDR_W-1:2])
        machines <= pwdata[REG_W-1:0];
      if (result_valid) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result count=%0d overflow=%0b",
                   $time, scheduled_count, overflow);
          fail_count++;
        end else begin
          exp_r = result_q.pop_front();
          if (scheduled_count !== exp_r.count) begin
            $display("%0t: scheduled_count expected %0d actual %0d",
                     $time, exp_r.count, scheduled_count);
            fail_count++;
          end
          if (overflow !== exp_r.ovf) begin
            $display("%0t: overflow expected %0b actual %0b", $time, exp_r.ovf, overflow);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (set_len < MAX_SHOWS) begin
          set_start[set_len] = show_start;
          set_end[set_len]   = show_end;
          set_len++;
        end else begin
          set_ovf = 1'b1;
        end
        if (last_show) begin
          // machine count as of the closing beat (a write on that same edge is not yet seen)
          exp_r.count = greedy_count(set_len, machines);
          exp_r.ovf   = set_ovf;
          result_q    = {result_q, exp_r};
          set_len = 0;
          set_ovf = 1'b0;
        end
      end
    end
  end
endmodule

// ===== test/tb_k_machine_interval_scheduler.sv =====
// Testbench top for the k-machine interval scheduler: clock, reset, APB writes and beats.
// Depends on kmis_pkg, k_machine_interval_scheduler and kmis_checker.
module tb_k_machine_interval_scheduler;
  import kmis_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 10_000_000;  // must outlast a full set at 64 machines

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               busy;
  logic [TIME_W-1:0]  show_start = '0, show_end = '0;
  logic               last_show = 1'b0;
  logic               result_valid;
  logic [CNT_W-1:0]   scheduled_count;
  logic               overflow;
  int                 fail_count, pending;
  int                 burst_left = 0;
  int                 idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  k_machine_interval_scheduler uut (.*);

  kmis_checker chk (.*);

  // watchdog: cycles in which neither channel nor the APB port moves a beat
  always @(posedge clk) begin
    if ((start && !busy) || result_valid || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // wait until all results are in and the scheduler is no longer busy
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_machines(logic [31:0] value);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_RECORDER_COUNT; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // one beat; sender idles between bursts, start held high between beats of a burst
  task automatic send_beat(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e, logic l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    start <= 1'b1;
    show_start <= s; show_end <= e; last_show <= l;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [TIME_W-1:0] pick_time(int span);
    if ($urandom_range(0, 15) == 0) return TIME_W'($urandom());
    return TIME_W'($urandom_range(0, span));
  endfunction

  task automatic random_set(int n, int span);
    for (int i = 0; i < n; i++)
      send_beat(pick_time(span), pick_time(span), i == n - 1);
  endtask

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset count of one machine, single intervals, time extremes
    send_beat('0, '0, 1'b1);
    send_beat('1, '1, 1'b1);
    send_beat(31'd0, '1, 1'b0);
    send_beat('1, 31'd0, 1'b1);           // end before start
    // equal ends keep arrival order; back-to-back fit
    write_machines(2);
    send_beat(31'd5, 31'd10, 1'b0);
    send_beat(31'd0, 31'd10, 1'b0);
    send_beat(31'd10, 31'd20, 1'b0);
    send_beat(31'd10, 31'd20, 1'b0);
    send_beat(31'd12, 31'd20, 1'b1);
    // zero machines schedule nothing
    write_machines(0);
    send_beat(31'd1, 31'd2, 1'b0);
    send_beat(31'd3, 31'd4, 1'b1);
    // above the maximum saturates
    write_machines(127);
    random_set(20, 40);
    write_machines(65);
    random_set(4, 40);
    write_machines(64);
    random_set(3, 40);

    // random sets, mostly small and dense in time so machines contend
    n = 0;
    while (n < 450) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 5))
          0:       write_machines(0);
          1:       write_machines(127);
          2:       write_machines(64);
          default: write_machines($urandom_range(1, 8));
        endcase
      end
      begin
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        random_set(len, $urandom_range(0, 3) == 0 ? 1000 : 30);
        n += len;
      end
    end

    // store full: beats past capacity dropped, the closing one too
    write_machines(1);
    random_set(MAX_SHOWS + 1, 3000);
    send_beat(31'd7, 31'd9, 1'b1);       // next set starts clean

    drain();
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
